@@ rtl/srta_pkg.sv @@
package srta_pkg;

    localparam int CFG_N = 8;
    localparam int CFG_IDX_W = 4;
    localparam int PROD_W = 48;
    localparam int W_W = 50;
    localparam int N_W = 56;
    localparam int D_W = 58;
    localparam int UN_W = 55;
    localparam int Q_W = 31;
    localparam int C_W = 50;
    localparam int ANG_W = 32;
    localparam int DIV_STEPS = 31;

    localparam logic [63:0] Q_RST_UNIT_LO = 64'd65536;
    localparam logic [63:0] Q_RST_UNIT_HI = 64'd281474976710656;
    localparam logic signed [ANG_W-1:0] ANG180 = 32'sd11796480;
    localparam logic signed [ANG_W-1:0] ANG90 = 32'sd5898240;
    localparam logic [30:0] GAIN_Q30 = 31'd1768195364;
    localparam logic signed [31:0] Q16_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] Q16_MIN = 32'sh80000000;

    typedef struct packed {
        logic [D_W-1:0] r;
        logic [Q_W-1:0] lo;
        logic [Q_W-1:0] q;
        logic neg;
        logic sat;
    } div_lane_t;

    typedef struct packed {
        logic signed [31:0] wx;
        logic signed [31:0] wy;
        logic signed [31:0] wz;
        logic signed [C_W-1:0] yg;
        logic fault;
    } yaw_side_t;

    typedef struct packed {
        logic signed [31:0] wx;
        logic signed [31:0] wy;
        logic signed [31:0] wz;
        logic signed [24:0] yaw;
        logic fault;
    } pitch_side_t;

    function automatic logic signed [ANG_W-1:0] atan_deg(input int i);
        logic signed [ANG_W-1:0] v;
        case (i)
            0: v = 32'sd2949120;
            1: v = 32'sd1740967;
            2: v = 32'sd919879;
            3: v = 32'sd466945;
            4: v = 32'sd234379;
            5: v = 32'sd117304;
            6: v = 32'sd58666;
            7: v = 32'sd29335;
            8: v = 32'sd14668;
            9: v = 32'sd7334;
            10: v = 32'sd3667;
            11: v = 32'sd1833;
            12: v = 32'sd917;
            13: v = 32'sd458;
            14: v = 32'sd229;
            15: v = 32'sd115;
            16: v = 32'sd57;
            17: v = 32'sd29;
            18: v = 32'sd14;
            19: v = 32'sd7;
            20: v = 32'sd4;
            21: v = 32'sd2;
            22: v = 32'sd1;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/srta_if.sv @@
interface srta_in_if;
    logic valid;
    logic ready;
    logic [14:0] pixel_x;
    logic [14:0] pixel_y;
    logic [14:0] disparity;
    modport source (output valid, output pixel_x, output pixel_y, output disparity,
                    input ready);
    modport sink (input valid, input pixel_x, input pixel_y, input disparity,
                  output ready);
endinterface

interface srta_out_if;
    logic valid;
    logic ready;
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
    logic signed [23:0] pitch_deg;
    logic signed [24:0] yaw_deg;
    logic div_fault;
    modport source (output valid, output world_x, output world_y, output world_z,
                    output pitch_deg, output yaw_deg, output div_fault, input ready);
    modport sink (input valid, input world_x, input world_y, input world_z,
                  input pitch_deg, input yaw_deg, input div_fault, output ready);
endinterface

@@ rtl/srta_matmul.sv @@
module srta_matmul (
    input  logic clk,
    input  logic rst_n,
    input  logic [srta_pkg::CFG_N-1:0][63:0] q,
    input  logic in_valid,
    output logic in_ready,
    input  logic [14:0] px,
    input  logic [14:0] py,
    input  logic [14:0] pd,
    output logic out_valid,
    input  logic out_ready,
    output logic [3:0][srta_pkg::W_W-1:0] w
);
    import srta_pkg::*;

    logic [1:0] v_reg;
    logic [1:0] adv;
    logic signed [31:0] ent [4][4];
    logic signed [15:0] vec [4];
    logic signed [PROD_W-1:0] prod_reg [4][4];
    logic [3:0][W_W-1:0] w_reg;

    always_comb
    begin
        vec[0] = $signed({1'b0, px});
        vec[1] = $signed({1'b0, py});
        vec[2] = $signed({1'b0, pd});
        vec[3] = 16'sd16;
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                ent[r][c] = $signed(q[r * 2 + c / 2][(c % 2) * 32 +: 32]);
            end
        end
    end

    assign adv[1] = !v_reg[1] || out_ready;
    assign adv[0] = !v_reg[0] || adv[1];
    assign in_ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 2'b00;
        end
        else
        begin
            if (adv[0])
            begin
                v_reg[0] <= in_valid;
            end
            if (adv[1])
            begin
                v_reg[1] <= v_reg[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            for (int r = 0; r < 4; r++)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    prod_reg[r][c] <= PROD_W'(ent[r][c]) * PROD_W'(vec[c]);
                end
            end
        end
        if (adv[1])
        begin
            for (int r = 0; r < 4; r++)
            begin
                w_reg[r] <= W_W'(prod_reg[r][0]) + W_W'(prod_reg[r][1])
                          + W_W'(prod_reg[r][2]) + W_W'(prod_reg[r][3]);
            end
        end
    end

    assign out_valid = v_reg[1];
    assign w = w_reg;

endmodule

@@ rtl/srta_div.sv @@
module srta_div (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic [3:0][srta_pkg::W_W-1:0] w,
    output logic out_valid,
    input  logic out_ready,
    output srta_pkg::yaw_side_t res
);
    import srta_pkg::*;

    localparam int NS = DIV_STEPS + 4;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] adv;

    logic signed [N_W-1:0] na_reg [3];
    logic signed [D_W:0] da_reg;
    logic fa_reg;

    div_lane_t lane_reg [DIV_STEPS+1][3];
    logic [D_W-1:0] ud_reg [DIV_STEPS+1];
    logic f_reg [DIV_STEPS+1];

    logic signed [31:0] wr_reg [3];
    logic fr_reg;
    yaw_side_t res_reg;

    logic [UN_W-1:0] un [3];
    logic [D_W-1:0] ud;
    logic signed [31:0] wres [3];
    logic [31:0] ay;
    logic [62:0] yprod;
    logic signed [C_W-1:0] ymag;

    always_comb
    begin
        adv[NS-1] = !v_reg[NS-1] || out_ready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            adv[i] = !v_reg[i] || adv[i+1];
        end
    end
    assign in_ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NS; i++)
            begin
                if (adv[i])
                begin
                    v_reg[i] <= (i == 0) ? in_valid : v_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            na_reg[0] <= N_W'($signed(w[0])) + N_W'($signed(w[3])) * 8'sd90;
            na_reg[1] <= N_W'($signed(w[1]));
            na_reg[2] <= N_W'($signed(w[2]));
            da_reg <= (D_W+1)'($signed(w[3])) * 11'sd1000;
            fa_reg <= ($signed(w[3]) == 0);
        end
    end

    always_comb
    begin
        ud = D_W'(da_reg[D_W] ? -da_reg : da_reg);
        for (int j = 0; j < 3; j++)
        begin
            un[j] = UN_W'(na_reg[j][N_W-1] ? -na_reg[j] : na_reg[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            ud_reg[0] <= ud;
            f_reg[0] <= fa_reg;
            for (int j = 0; j < 3; j++)
            begin
                lane_reg[0][j].r <= D_W'(un[j][UN_W-1:15]);
                lane_reg[0][j].lo <= {un[j][14:0], 16'b0};
                lane_reg[0][j].q <= '0;
                lane_reg[0][j].neg <= na_reg[j][N_W-1] ^ da_reg[D_W];
                lane_reg[0][j].sat <= ({18'b0, un[j]} >= {ud, 15'b0});
            end
        end
    end

    for (genvar k = 1; k <= DIV_STEPS; k++)
    begin : g_step
        logic [D_W:0] rs [3];
        logic ge [3];
        always_comb
        begin
            for (int j = 0; j < 3; j++)
            begin
                rs[j] = {lane_reg[k-1][j].r, lane_reg[k-1][j].lo[Q_W-1]};
                ge[j] = (rs[j] >= {1'b0, ud_reg[k-1]});
            end
        end
        always_ff @(posedge clk)
        begin
            if (adv[k+1])
            begin
                ud_reg[k] <= ud_reg[k-1];
                f_reg[k] <= f_reg[k-1];
                for (int j = 0; j < 3; j++)
                begin
                    lane_reg[k][j].r <= ge[j] ? D_W'(rs[j] - {1'b0, ud_reg[k-1]})
                                              : D_W'(rs[j]);
                    lane_reg[k][j].lo <= {lane_reg[k-1][j].lo[Q_W-2:0], 1'b0};
                    lane_reg[k][j].q <= {lane_reg[k-1][j].q[Q_W-2:0], ge[j]};
                    lane_reg[k][j].neg <= lane_reg[k-1][j].neg;
                    lane_reg[k][j].sat <= lane_reg[k-1][j].sat;
                end
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            if (f_reg[DIV_STEPS])
            begin
                wres[j] = '0;
            end
            else if (lane_reg[DIV_STEPS][j].sat)
            begin
                wres[j] = lane_reg[DIV_STEPS][j].neg ? Q16_MIN : Q16_MAX;
            end
            else if (lane_reg[DIV_STEPS][j].neg)
            begin
                wres[j] = -$signed({1'b0, lane_reg[DIV_STEPS][j].q});
            end
            else
            begin
                wres[j] = $signed({1'b0, lane_reg[DIV_STEPS][j].q});
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[NS-2])
        begin
            for (int j = 0; j < 3; j++)
            begin
                wr_reg[j] <= wres[j];
            end
            fr_reg <= f_reg[DIV_STEPS];
        end
    end

    always_comb
    begin
        ay = wr_reg[1][31] ? 32'(-wr_reg[1]) : 32'(wr_reg[1]);
        yprod = 63'(ay) * 63'(GAIN_Q30);
        ymag = $signed({5'b0, yprod[62:18]});
    end

    always_ff @(posedge clk)
    begin
        if (adv[NS-1])
        begin
            res_reg.wx <= wr_reg[0];
            res_reg.wy <= wr_reg[1];
            res_reg.wz <= wr_reg[2];
            res_reg.yg <= wr_reg[1][31] ? -ymag : ymag;
            res_reg.fault <= fr_reg;
        end
    end

    assign out_valid = v_reg[NS-1];
    assign res = res_reg;

endmodule

@@ rtl/srta_cordic.sv @@
module srta_cordic #(
    parameter int STEPS = 20,
    parameter int SW = 1
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic signed [srta_pkg::C_W-1:0] in_a,
    input  logic signed [srta_pkg::C_W-1:0] in_b,
    input  logic [SW-1:0] in_side,
    output logic out_valid,
    input  logic out_ready,
    output logic signed [srta_pkg::C_W-1:0] out_a,
    output logic signed [srta_pkg::ANG_W-1:0] out_ang,
    output logic [SW-1:0] out_side
);
    import srta_pkg::*;

    localparam int NS = STEPS + 1;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] adv;
    logic signed [C_W-1:0] a_reg [NS];
    logic signed [C_W-1:0] b_reg [NS];
    logic signed [ANG_W-1:0] ang_reg [NS];
    logic z_reg [NS];
    logic [SW-1:0] side_reg [NS];

    always_comb
    begin
        adv[NS-1] = !v_reg[NS-1] || out_ready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            adv[i] = !v_reg[i] || adv[i+1];
        end
    end
    assign in_ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NS; i++)
            begin
                if (adv[i])
                begin
                    v_reg[i] <= (i == 0) ? in_valid : v_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            z_reg[0] <= (in_a == 0) && (in_b == 0);
            side_reg[0] <= in_side;
            if (in_a < 0)
            begin
                a_reg[0] <= -in_a;
                b_reg[0] <= -in_b;
                ang_reg[0] <= (in_b < 0) ? -ANG180 : ANG180;
            end
            else
            begin
                a_reg[0] <= in_a;
                b_reg[0] <= in_b;
                ang_reg[0] <= '0;
            end
        end
    end

    for (genvar k = 1; k < NS; k++)
    begin : g_iter
        always_ff @(posedge clk)
        begin
            if (adv[k])
            begin
                z_reg[k] <= z_reg[k-1];
                side_reg[k] <= side_reg[k-1];
                if (b_reg[k-1] >= 0)
                begin
                    a_reg[k] <= a_reg[k-1] + (b_reg[k-1] >>> (k - 1));
                    b_reg[k] <= b_reg[k-1] - (a_reg[k-1] >>> (k - 1));
                    ang_reg[k] <= ang_reg[k-1] + atan_deg(k - 1);
                end
                else
                begin
                    a_reg[k] <= a_reg[k-1] - (b_reg[k-1] >>> (k - 1));
                    b_reg[k] <= b_reg[k-1] + (a_reg[k-1] >>> (k - 1));
                    ang_reg[k] <= ang_reg[k-1] - atan_deg(k - 1);
                end
            end
        end
    end

    assign out_valid = v_reg[NS-1];
    assign out_a = a_reg[NS-1];
    assign out_ang = z_reg[NS-1] ? '0 : ang_reg[NS-1];
    assign out_side = side_reg[NS-1];

endmodule

@@ rtl/stereo_reproject_to_aim_angles.sv @@
// Throughput: one item per cycle; every stage holds one item and a stalled output
// holds only the stages behind it, so bubbles ahead still fill.
// The 31-step divider and the two CORDIC chains each run one step per pipeline stage.
// Reset is asynchronous and active low: it empties the pipeline and loads the
// identity reprojection matrix.
module stereo_reproject_to_aim_angles #(
    parameter int CORDIC_STEPS = 20
) (
    input  logic clk,
    input  logic rst_n,
    srta_in_if.sink pixel,
    srta_out_if.source aim,
    input  logic cfg_we,
    input  logic [srta_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0] cfg_data
);
    import srta_pkg::*;

    logic [CFG_N-1:0][63:0] q_reg;

    logic mm_valid;
    logic mm_ready;
    logic [3:0][W_W-1:0] mm_w;
    logic dv_valid;
    logic dv_ready;
    yaw_side_t dv_res;
    logic yw_valid;
    logic yw_ready;
    logic signed [C_W-1:0] yw_mag;
    logic signed [ANG_W-1:0] yw_ang;
    logic [$bits(yaw_side_t)-1:0] yw_side_bits;
    yaw_side_t yw_side;
    pitch_side_t pin_side;
    logic pt_valid;
    logic pt_ready;
    logic signed [C_W-1:0] pt_mag;
    logic signed [ANG_W-1:0] pt_ang;
    logic [$bits(pitch_side_t)-1:0] pt_side_bits;
    pitch_side_t pt_side;
    logic signed [ANG_W-1:0] yaw_cl;
    logic signed [ANG_W-1:0] pitch_cl;
    logic out_v_reg;
    logic adv_o;
    logic signed [31:0] wx_reg;
    logic signed [31:0] wy_reg;
    logic signed [31:0] wz_reg;
    logic signed [23:0] pitch_reg;
    logic signed [24:0] yaw_reg;
    logic fault_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg[0] <= Q_RST_UNIT_LO;
            q_reg[1] <= '0;
            q_reg[2] <= Q_RST_UNIT_HI;
            q_reg[3] <= '0;
            q_reg[4] <= '0;
            q_reg[5] <= Q_RST_UNIT_LO;
            q_reg[6] <= '0;
            q_reg[7] <= Q_RST_UNIT_HI;
        end
        else if (cfg_we && (cfg_index < CFG_IDX_W'(CFG_N)))
        begin
            q_reg[cfg_index[$clog2(CFG_N)-1:0]] <= cfg_data;
        end
    end

    srta_matmul u_matmul (
        .clk(clk),
        .rst_n(rst_n),
        .q(q_reg),
        .in_valid(pixel.valid),
        .in_ready(pixel.ready),
        .px(pixel.pixel_x),
        .py(pixel.pixel_y),
        .pd(pixel.disparity),
        .out_valid(mm_valid),
        .out_ready(mm_ready),
        .w(mm_w)
    );

    srta_div u_div (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(mm_valid),
        .in_ready(mm_ready),
        .w(mm_w),
        .out_valid(dv_valid),
        .out_ready(dv_ready),
        .res(dv_res)
    );

    srta_cordic #(
        .STEPS(CORDIC_STEPS),
        .SW($bits(yaw_side_t))
    ) u_cordic_yaw (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(dv_valid),
        .in_ready(dv_ready),
        .in_a(C_W'(dv_res.wz) <<< 12),
        .in_b(C_W'(dv_res.wx) <<< 12),
        .in_side(dv_res),
        .out_valid(yw_valid),
        .out_ready(yw_ready),
        .out_a(yw_mag),
        .out_ang(yw_ang),
        .out_side(yw_side_bits)
    );

    always_comb
    begin
        yw_side = yaw_side_t'(yw_side_bits);
        if (yw_ang > ANG180)
        begin
            yaw_cl = ANG180;
        end
        else if (yw_ang < -ANG180)
        begin
            yaw_cl = -ANG180;
        end
        else
        begin
            yaw_cl = yw_ang;
        end
        pin_side.wx = yw_side.wx;
        pin_side.wy = yw_side.wy;
        pin_side.wz = yw_side.wz;
        pin_side.yaw = yaw_cl[24:0];
        pin_side.fault = yw_side.fault;
    end

    srta_cordic #(
        .STEPS(CORDIC_STEPS),
        .SW($bits(pitch_side_t))
    ) u_cordic_pitch (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(yw_valid),
        .in_ready(yw_ready),
        .in_a(yw_mag),
        .in_b(yw_side.yg),
        .in_side(pin_side),
        .out_valid(pt_valid),
        .out_ready(pt_ready),
        .out_a(pt_mag),
        .out_ang(pt_ang),
        .out_side(pt_side_bits)
    );

    always_comb
    begin
        pt_side = pitch_side_t'(pt_side_bits);
        if (pt_ang > ANG90)
        begin
            pitch_cl = -ANG90;
        end
        else if (pt_ang < -ANG90)
        begin
            pitch_cl = ANG90;
        end
        else
        begin
            pitch_cl = -pt_ang;
        end
    end

    assign adv_o = !out_v_reg || aim.ready;
    assign pt_ready = adv_o;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (adv_o)
        begin
            out_v_reg <= pt_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_o)
        begin
            wx_reg <= pt_side.wx;
            wy_reg <= pt_side.wy;
            wz_reg <= pt_side.wz;
            fault_reg <= pt_side.fault;
            yaw_reg <= pt_side.fault ? '0 : pt_side.yaw;
            pitch_reg <= (pt_side.fault || (pt_mag == 0 && pt_ang == 0)) ? '0
                                                                         : pitch_cl[23:0];
        end
    end

    assign aim.valid = out_v_reg;
    assign aim.world_x = wx_reg;
    assign aim.world_y = wy_reg;
    assign aim.world_z = wz_reg;
    assign aim.pitch_deg = pitch_reg;
    assign aim.yaw_deg = yaw_reg;
    assign aim.div_fault = fault_reg;

endmodule
